@@ src/dsf_pkg.sv @@
// Shared types, constants and step functions of the damped spring force unit.
package dsf_pkg;

	localparam int SqrtSteps = 33;
	localparam int DampSteps = 62;
	localparam int GradSteps = 31;

	typedef enum logic [1:0] {
		REG_STIFFNESS   = 2'd0,
		REG_REST_LENGTH = 2'd1,
		REG_DAMPING     = 2'd2
	} reg_idx_t;

	// Geometry that rides along the pipe after the square root.
	typedef struct packed {
		logic [31:0] dxm;
		logic [31:0] dym;
		logic        dxn;
		logic        dyn;
		logic [32:0] l;
	} keep_t;

	typedef struct packed {
		logic [31:0]        dxm;
		logic [31:0]        dym;
		logic               dxn;
		logic               dyn;
		logic signed [49:0] p;
		logic [65:0]        rad;
	} front_t;

	typedef struct packed {
		keep_t              keep;
		logic signed [49:0] p;
	} root_t;

	typedef struct packed {
		keep_t              keep;
		logic               zero;
		logic signed [49:0] t;
		logic [80:0]        num;
		logic               dneg;
		logic               dsat;
		logic [31:0]        energy;
	} damp_t;

	typedef struct packed {
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic [31:0]        energy;
		logic               zero;
	} res_t;

	typedef struct packed {
		logic [35:0] rem;
		logic [32:0] root;
	} sq_t;

	typedef struct packed {
		logic [32:0] rem;
		logic        q;
	} dv_t;

	// One digit of the bitwise integer square root.
	function automatic sq_t sqrt_step(input logic [35:0] rem, input logic [32:0] root,
		input logic [1:0] pair);
		logic [35:0] cur;
		logic [35:0] trial;
		sq_t         r;
		cur   = {rem[33:0], pair};
		trial = {1'b0, root, 2'b01};
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {root[31:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {root[31:0], 1'b0};
		end
		return r;
	endfunction

	// One bit of restoring division; the remainder stays below the divisor if it entered below it.
	function automatic dv_t div_step(input logic [32:0] rem, input logic nb,
		input logic [32:0] d);
		logic [33:0] cur;
		logic [33:0] diff;
		dv_t         r;
		cur  = {rem, nb};
		diff = cur - {1'b0, d};
		if (cur >= {1'b0, d}) begin
			r.rem = diff[32:0];
			r.q   = 1'b1;
		end else begin
			r.rem = cur[32:0];
			r.q   = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ src/dsf_front.sv @@
// Endpoint differences, magnitudes, squares and the relative velocity projection.
module dsf_front import dsf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  logic [255:0] in_data,
	output logic         out_valid,
	output front_t       out_data
);

	logic [4:1] v_s;

	logic signed [32:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [31:0] dxm_s2, dym_s2, dvxm_s2, dvym_s2;
	logic        dxn_s2, dyn_s2, dvxn_s2, dvyn_s2;
	logic [31:0] dxm_s3, dym_s3;
	logic        dxn_s3, dyn_s3, pxn_s3, pyn_s3;
	logic [63:0] xx_s3, yy_s3, px_s3, py_s3;
	logic [31:0] dxm_s4, dym_s4;
	logic        dxn_s4, dyn_s4;
	logic [65:0] rad_s4;
	logic signed [49:0] p_s4;

	logic signed [32:0] ndx, ndy, ndvx, ndvy;
	logic signed [49:0] tx, ty;

	function automatic logic signed [32:0] sub33(input logic [31:0] a, input logic [31:0] b);
		return $signed({a[31], a}) - $signed({b[31], b});
	endfunction

	always_comb begin
		ndx  = -dx_s1;
		ndy  = -dy_s1;
		ndvx = -dvx_s1;
		ndvy = -dvy_s1;
		tx   = pxn_s3 ? -$signed({2'b00, px_s3[63:16]}) : $signed({2'b00, px_s3[63:16]});
		ty   = pyn_s3 ? -$signed({2'b00, py_s3[63:16]}) : $signed({2'b00, py_s3[63:16]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[3:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= sub33(in_data[95:64], in_data[31:0]);
			dy_s1  <= sub33(in_data[127:96], in_data[63:32]);
			dvx_s1 <= sub33(in_data[223:192], in_data[159:128]);
			dvy_s1 <= sub33(in_data[255:224], in_data[191:160]);

			dxn_s2  <= dx_s1[32];
			dyn_s2  <= dy_s1[32];
			dvxn_s2 <= dvx_s1[32];
			dvyn_s2 <= dvy_s1[32];
			dxm_s2  <= dx_s1[32] ? ndx[31:0] : dx_s1[31:0];
			dym_s2  <= dy_s1[32] ? ndy[31:0] : dy_s1[31:0];
			dvxm_s2 <= dvx_s1[32] ? ndvx[31:0] : dvx_s1[31:0];
			dvym_s2 <= dvy_s1[32] ? ndvy[31:0] : dvy_s1[31:0];

			dxm_s3 <= dxm_s2;
			dym_s3 <= dym_s2;
			dxn_s3 <= dxn_s2;
			dyn_s3 <= dyn_s2;
			pxn_s3 <= dxn_s2 ^ dvxn_s2;
			pyn_s3 <= dyn_s2 ^ dvyn_s2;
			xx_s3  <= dxm_s2 * dxm_s2;
			yy_s3  <= dym_s2 * dym_s2;
			px_s3  <= dxm_s2 * dvxm_s2;
			py_s3  <= dym_s2 * dvym_s2;

			dxm_s4 <= dxm_s3;
			dym_s4 <= dym_s3;
			dxn_s4 <= dxn_s3;
			dyn_s4 <= dyn_s3;
			rad_s4 <= {2'b00, xx_s3} + {2'b00, yy_s3};
			p_s4   <= tx + ty;
		end
	end

	always_comb begin
		out_valid    = v_s[4];
		out_data.dxm = dxm_s4;
		out_data.dym = dym_s4;
		out_data.dxn = dxn_s4;
		out_data.dyn = dyn_s4;
		out_data.p   = p_s4;
		out_data.rad = rad_s4;
	end

endmodule

@@ src/dsf_sqrt.sv @@
// Pipelined integer square root of the squared length, one result bit per stage.
module dsf_sqrt import dsf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  front_t in_data,
	output logic   out_valid,
	output root_t  out_data
);

	logic [SqrtSteps:1] v_s;
	logic [35:0]        rem_s  [1:SqrtSteps];
	logic [32:0]        root_s [1:SqrtSteps];
	front_t             side_s [1:SqrtSteps];
	sq_t                nxt    [1:SqrtSteps];

	always_comb begin
		nxt[1] = sqrt_step(36'd0, 33'd0, in_data.rad[65:64]);
		for (int j = 2; j <= SqrtSteps; j++) begin
			nxt[j] = sqrt_step(rem_s[j-1], root_s[j-1], side_s[j-1].rad[2*(SqrtSteps-j) +: 2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[SqrtSteps-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= in_data;
			rem_s[1]  <= nxt[1].rem;
			root_s[1] <= nxt[1].root;
			for (int j = 2; j <= SqrtSteps; j++) begin
				side_s[j] <= side_s[j-1];
				rem_s[j]  <= nxt[j].rem;
				root_s[j] <= nxt[j].root;
			end
		end
	end

	always_comb begin
		out_valid         = v_s[SqrtSteps];
		out_data.keep.dxm = side_s[SqrtSteps].dxm;
		out_data.keep.dym = side_s[SqrtSteps].dym;
		out_data.keep.dxn = side_s[SqrtSteps].dxn;
		out_data.keep.dyn = side_s[SqrtSteps].dyn;
		out_data.keep.l   = root_s[SqrtSteps];
		out_data.p        = side_s[SqrtSteps].p;
	end

endmodule

@@ src/dsf_scale.sv @@
// Length error, stiffness term, damping numerator and the saturated spring energy.
module dsf_scale import dsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [31:0] stiffness,
	input  logic [31:0] rest_length,
	input  logic [31:0] damping,
	input  logic        in_valid,
	input  root_t       in_data,
	output logic        out_valid,
	output damp_t       out_data
);

	logic [6:1] v_s;
	keep_t keep_s1, keep_s2, keep_s3, keep_s4, keep_s5, keep_s6;
	logic  zero_s1, zero_s2, zero_s3, zero_s4, zero_s5, zero_s6;
	logic  pn_s1, pn_s2, pn_s3, pn_s4, pn_s5, pn_s6;

	logic signed [33:0] e_s1;
	logic [48:0]        pm_s1, pm_s2;
	logic [32:0]        em_s2;
	logic               eneg_s2, eneg_s3;
	logic [64:0]        ke_s3;
	logic [65:0]        ee_s3;
	logic [56:0]        bl_s3;
	logic [55:0]        bh_s3;
	logic signed [49:0] t_s4, t_s5, t_s6;
	logic [49:0]        sq_s4;
	logic [80:0]        num_s4, num_s5, num_s6;
	logic [56:0]        kl_s5, kh_s5;
	logic               dsat_s5, dsat_s6;
	logic [31:0]        energy_s6;

	logic signed [49:0] pneg;
	logic signed [33:0] eneg;
	logic [81:0]        full;

	always_comb begin
		pneg = -in_data.p;
		eneg = -e_s1;
		full = {kh_s5, 25'd0} + {25'd0, kl_s5};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[5:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			keep_s1 <= in_data.keep;
			zero_s1 <= (in_data.keep.l == 33'd0);
			pn_s1   <= in_data.p[49];
			pm_s1   <= in_data.p[49] ? pneg[48:0] : in_data.p[48:0];
			e_s1    <= $signed({1'b0, in_data.keep.l}) - $signed({2'b00, rest_length});

			keep_s2 <= keep_s1;
			zero_s2 <= zero_s1;
			pn_s2   <= pn_s1;
			pm_s2   <= pm_s1;
			eneg_s2 <= e_s1[33];
			em_s2   <= e_s1[33] ? eneg[32:0] : e_s1[32:0];

			keep_s3 <= keep_s2;
			zero_s3 <= zero_s2;
			pn_s3   <= pn_s2;
			eneg_s3 <= eneg_s2;
			ke_s3   <= stiffness * em_s2;
			ee_s3   <= em_s2 * em_s2;
			bl_s3   <= damping * pm_s2[24:0];
			bh_s3   <= damping * pm_s2[48:25];

			keep_s4 <= keep_s3;
			zero_s4 <= zero_s3;
			pn_s4   <= pn_s3;
			t_s4    <= eneg_s3 ? -$signed({1'b0, ke_s3[64:16]}) : $signed({1'b0, ke_s3[64:16]});
			sq_s4   <= ee_s3[65:16];
			num_s4  <= {bh_s3, 25'd0} + {24'd0, bl_s3};

			keep_s5 <= keep_s4;
			zero_s5 <= zero_s4;
			pn_s5   <= pn_s4;
			t_s5    <= t_s4;
			num_s5  <= num_s4;
			kl_s5   <= stiffness * sq_s4[24:0];
			kh_s5   <= stiffness * sq_s4[49:25];
			// A quotient of 2^62 or more clamps; that is the case when the top bits reach l.
			dsat_s5 <= ({14'd0, num_s4[80:62]} >= keep_s4.l);

			keep_s6   <= keep_s5;
			zero_s6   <= zero_s5;
			pn_s6     <= pn_s5;
			t_s6      <= t_s5;
			num_s6    <= num_s5;
			dsat_s6   <= dsat_s5;
			energy_s6 <= (|full[81:49]) ? 32'hFFFF_FFFF : full[48:17];
		end
	end

	always_comb begin
		out_valid       = v_s[6];
		out_data.keep   = keep_s6;
		out_data.zero   = zero_s6;
		out_data.t      = t_s6;
		out_data.num    = num_s6;
		out_data.dneg   = pn_s6;
		out_data.dsat   = dsat_s6;
		out_data.energy = energy_s6;
	end

endmodule

@@ src/dsf_damp_div.sv @@
// Pipelined restoring divider for the damping term b*P/l, one quotient bit per stage.
module dsf_damp_div import dsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  damp_t       in_data,
	output logic        out_valid,
	output damp_t       out_data,
	output logic [61:0] out_q
);

	logic [DampSteps:1] v_s;
	logic [32:0]        rem_s  [1:DampSteps];
	logic [61:0]        q_s    [1:DampSteps];
	damp_t              side_s [1:DampSteps];
	dv_t                nxt    [1:DampSteps];

	always_comb begin
		nxt[1] = div_step({14'd0, in_data.num[80:62]}, in_data.num[DampSteps-1], in_data.keep.l);
		for (int j = 2; j <= DampSteps; j++) begin
			nxt[j] = div_step(rem_s[j-1], side_s[j-1].num[DampSteps-j], side_s[j-1].keep.l);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DampSteps-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= in_data;
			rem_s[1]  <= nxt[1].rem;
			q_s[1]    <= {61'd0, nxt[1].q};
			for (int j = 2; j <= DampSteps; j++) begin
				side_s[j] <= side_s[j-1];
				rem_s[j]  <= nxt[j].rem;
				q_s[j]    <= {q_s[j-1][60:0], nxt[j].q};
			end
		end
	end

	always_comb begin
		out_valid = v_s[DampSteps];
		out_data  = side_s[DampSteps];
		out_q     = q_s[DampSteps];
	end

endmodule

@@ src/dsf_grad.sv @@
// Force coefficient, projection onto the unit direction and the output register.
module dsf_grad import dsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  damp_t       in_data,
	input  logic [61:0] in_q,
	output logic        out_valid,
	output res_t        out_data
);

	localparam int PreStages = 6;
	localparam int Stages    = PreStages + GradSteps;

	typedef struct packed {
		logic        zero;
		logic [31:0] energy;
		logic [32:0] l;
		logic        xn;
		logic        yn;
		logic        xsat;
		logic        ysat;
		logic [30:0] xlow;
		logic [30:0] ylow;
	} gside_t;

	logic [Stages:1] v_s;
	keep_t keep_s1, keep_s2, keep_s3, keep_s4, keep_s5;
	logic  zero_s1, zero_s2, zero_s3, zero_s4, zero_s5;
	logic [31:0] en_s1, en_s2, en_s3, en_s4, en_s5;
	logic signed [49:0] t_s1;
	logic signed [63:0] dsig_s1, c_s2;
	logic [62:0] cm_s3;
	logic        xn_s3, yn_s3, xn_s4, yn_s4, xn_s5, yn_s5;
	logic [63:0] xl_s4, yl_s4;
	logic [62:0] xh_s4, yh_s4;
	logic [94:0] nx_s5, ny_s5;
	gside_t      side_s6;
	logic [32:0] xrem_s6, yrem_s6;

	gside_t      side_s [1:GradSteps];
	logic [32:0] xr_s   [1:GradSteps];
	logic [32:0] yr_s   [1:GradSteps];
	logic [30:0] xq_s   [1:GradSteps];
	logic [30:0] yq_s   [1:GradSteps];
	dv_t         xnx    [1:GradSteps];
	dv_t         ynx    [1:GradSteps];

	logic               out_valid_q;
	res_t               res_q;
	logic [62:0]        dm;
	logic signed [63:0] cneg;
	gside_t             last;

	function automatic logic [31:0] pick(input logic zero, input logic sat, input logic neg,
		input logic [30:0] q);
		logic [31:0] m;
		m = {1'b0, q};
		if (zero) begin
			return 32'd0;
		end else if (sat) begin
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return neg ? -m : m;
	endfunction

	always_comb begin
		dm   = in_data.dsat ? {1'b1, 62'd0} : {1'b0, in_q};
		cneg = -c_s2;
		xnx[1] = div_step(xrem_s6, side_s6.xlow[GradSteps-1], side_s6.l);
		ynx[1] = div_step(yrem_s6, side_s6.ylow[GradSteps-1], side_s6.l);
		for (int j = 2; j <= GradSteps; j++) begin
			xnx[j] = div_step(xr_s[j-1], side_s[j-1].xlow[GradSteps-j], side_s[j-1].l);
			ynx[j] = div_step(yr_s[j-1], side_s[j-1].ylow[GradSteps-j], side_s[j-1].l);
		end
		last = side_s[GradSteps];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s         <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s         <= {v_s[Stages-1:1], in_valid};
			out_valid_q <= v_s[Stages];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			keep_s1 <= in_data.keep;
			zero_s1 <= in_data.zero;
			en_s1   <= in_data.energy;
			t_s1    <= in_data.t;
			dsig_s1 <= in_data.dneg ? -$signed({1'b0, dm}) : $signed({1'b0, dm});

			keep_s2 <= keep_s1;
			zero_s2 <= zero_s1;
			en_s2   <= en_s1;
			c_s2    <= {{14{t_s1[49]}}, t_s1} + dsig_s1;

			keep_s3 <= keep_s2;
			zero_s3 <= zero_s2;
			en_s3   <= en_s2;
			cm_s3   <= c_s2[63] ? cneg[62:0] : c_s2[62:0];
			xn_s3   <= c_s2[63] ^ keep_s2.dxn;
			yn_s3   <= c_s2[63] ^ keep_s2.dyn;

			keep_s4 <= keep_s3;
			zero_s4 <= zero_s3;
			en_s4   <= en_s3;
			xn_s4   <= xn_s3;
			yn_s4   <= yn_s3;
			xl_s4   <= cm_s3[31:0] * keep_s3.dxm;
			xh_s4   <= cm_s3[62:32] * keep_s3.dxm;
			yl_s4   <= cm_s3[31:0] * keep_s3.dym;
			yh_s4   <= cm_s3[62:32] * keep_s3.dym;

			keep_s5 <= keep_s4;
			zero_s5 <= zero_s4;
			en_s5   <= en_s4;
			xn_s5   <= xn_s4;
			yn_s5   <= yn_s4;
			nx_s5   <= {xh_s4, 32'd0} + {31'd0, xl_s4};
			ny_s5   <= {yh_s4, 32'd0} + {31'd0, yl_s4};

			// A quotient of 2^31 or more only saturates, so the divide keeps 31 bits.
			side_s6.zero   <= zero_s5;
			side_s6.energy <= en_s5;
			side_s6.l      <= keep_s5.l;
			side_s6.xn     <= xn_s5;
			side_s6.yn     <= yn_s5;
			side_s6.xsat   <= (nx_s5[94:31] >= {31'd0, keep_s5.l});
			side_s6.ysat   <= (ny_s5[94:31] >= {31'd0, keep_s5.l});
			side_s6.xlow   <= nx_s5[30:0];
			side_s6.ylow   <= ny_s5[30:0];
			xrem_s6        <= nx_s5[63:31];
			yrem_s6        <= ny_s5[63:31];

			side_s[1] <= side_s6;
			xr_s[1]   <= xnx[1].rem;
			yr_s[1]   <= ynx[1].rem;
			xq_s[1]   <= {30'd0, xnx[1].q};
			yq_s[1]   <= {30'd0, ynx[1].q};
			for (int j = 2; j <= GradSteps; j++) begin
				side_s[j] <= side_s[j-1];
				xr_s[j]   <= xnx[j].rem;
				yr_s[j]   <= ynx[j].rem;
				xq_s[j]   <= {xq_s[j-1][29:0], xnx[j].q};
				yq_s[j]   <= {yq_s[j-1][29:0], ynx[j].q};
			end

			res_q.grad_x <= pick(last.zero, last.xsat, last.xn, xq_s[GradSteps]);
			res_q.grad_y <= pick(last.zero, last.ysat, last.yn, yq_s[GradSteps]);
			res_q.energy <= last.energy;
			res_q.zero   <= last.zero;
		end
	end

	always_comb begin
		out_valid = out_valid_q;
		out_data  = res_q;
	end

endmodule

@@ src/damped_spring_force_2d_unit.sv @@
// Damped 2D spring evaluator: one spring per cycle in, gradient and energy out.
// Each input word carries the positions and velocities of a spring's two endpoints
// in Q16.16. The result word holds g = (k(l-l0) + b(n.dv)) n, saturated to 32 bits,
// and the energy 0.5k(l-l0)^2, saturated unsigned; subtract g at the first endpoint
// and add it at the second. Coincident endpoints give a zero gradient with the
// zero-length flag set. A new word is taken every cycle unless the output stalls.
// It uses the 33-stage square root and the 62-stage and 31-stage bit-per-stage dividers.
// The whole pipe holds while a result waits and the output is not ready. Write the
// stiffness, rest length and damping registers only while no word is in flight.
module damped_spring_force_2d_unit import dsf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// first_px, first_py, second_px, second_py, first_vx, first_vy, second_vx, second_vy
	input  logic [255:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// grad_x, grad_y, energy
	output logic [95:0]  m_axis_tdata,
	// zero_length
	output logic [0:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	logic [31:0] stiffness_q, rest_length_q, damping_q;
	logic        en;
	logic        f_valid, r_valid, s_valid, d_valid, o_valid;
	front_t      f_data;
	root_t       r_data;
	damp_t       s_data, d_data;
	logic [61:0] d_q;
	res_t        o_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q   <= 32'h0001_0000;
			rest_length_q <= 32'h0001_0000;
			damping_q     <= 32'd0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_STIFFNESS:   stiffness_q   <= cfg_data;
				REG_REST_LENGTH: rest_length_q <= cfg_data;
				REG_DAMPING:     damping_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en            = !o_valid || m_axis_tready;
	assign s_axis_tready = en;

	dsf_front u_front (
		.clk, .arst_n, .en,
		.in_valid  (s_axis_tvalid),
		.in_data   (s_axis_tdata),
		.out_valid (f_valid),
		.out_data  (f_data)
	);

	dsf_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.in_valid  (f_valid),
		.in_data   (f_data),
		.out_valid (r_valid),
		.out_data  (r_data)
	);

	dsf_scale u_scale (
		.clk, .arst_n, .en,
		.stiffness   (stiffness_q),
		.rest_length (rest_length_q),
		.damping     (damping_q),
		.in_valid    (r_valid),
		.in_data     (r_data),
		.out_valid   (s_valid),
		.out_data    (s_data)
	);

	dsf_damp_div u_damp (
		.clk, .arst_n, .en,
		.in_valid  (s_valid),
		.in_data   (s_data),
		.out_valid (d_valid),
		.out_data  (d_data),
		.out_q     (d_q)
	);

	dsf_grad u_grad (
		.clk, .arst_n, .en,
		.in_valid  (d_valid),
		.in_data   (d_data),
		.in_q      (d_q),
		.out_valid (o_valid),
		.out_data  (o_data)
	);

	assign m_axis_tvalid = o_valid;
	assign m_axis_tdata  = {o_data.energy, o_data.grad_y, o_data.grad_x};
	assign m_axis_tuser  = o_data.zero;

endmodule

@@ src/dsf_checker.sv @@
// Port-level checks of the spring unit and their binding to the top level.
module dsf_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [255:0] s_axis_tdata,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [95:0]  m_axis_tdata,
	input logic [0:0]   m_axis_tuser,
	input logic         cfg_we,
	input logic [1:0]   cfg_index,
	input logic [31:0]  cfg_data
);

	// A coincident spring never carries a gradient.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[63:0] == 64'd0)
		else $error("zero-length word with nonzero gradient");

	// A waiting result blocks the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

	// With the output empty or draining, the input is always open.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("input blocked with output free");

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("stalled result word changed");

endmodule

bind damped_spring_force_2d_unit dsf_checker u_dsf_checker (.*);
